[rtl/pfa_pkg.sv]
// pfa_pkg: shared types and constants for the page frame allocator
// no dependencies; imported by pfa_scan_unit and page_frame_allocator
package pfa_pkg;

	// bitmap group geometry and field widths
	localparam int GROUP_BITS = 8;
	localparam int PAGE_W     = 7;
	localparam int USABLE_W   = 5;
	localparam logic [GROUP_BITS-1:0] FULL_GROUP = 8'hFF;
	localparam logic [GROUP_BITS-1:0] GROUP0_RESET = 8'h01;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_CLR,
		ST_SCAN,
		ST_DONE
	} state_t;

	// what the shared scan unit reports about one bitmap group
	typedef struct packed {
		logic                  full;
		logic [2:0]            bit_idx;
		logic [GROUP_BITS-1:0] set_val;
	} scan_res_t;

endpackage

[rtl/pfa_scan_unit.sv]
// pfa_scan_unit: checks one bitmap group per cycle for a free page
// depends on pfa_pkg; instantiated by page_frame_allocator
module pfa_scan_unit import pfa_pkg::*; #(
	parameter int PAGE_COUNT = 128,
	parameter int GROUP_W    = 4
) (
	input  logic [GROUP_W-1:0]    grp,
	input  logic [GROUP_BITS-1:0] data,
	input  logic [USABLE_W-1:0]   usable,
	output scan_res_t             res
);

	localparam int GROUP_COUNT = (PAGE_COUNT + GROUP_BITS - 1) / GROUP_BITS;
	localparam int LAST_VALID  = PAGE_COUNT - GROUP_BITS * (GROUP_COUNT - 1);
	localparam logic [GROUP_BITS-1:0] LAST_PAD = 8'(16'h00FF << LAST_VALID);

	logic [GROUP_BITS-1:0] seen;
	logic [2:0]            idx;

	// group as the scan sees it: unusable groups full, missing pages busy
	always_comb begin
		if (5'(grp) >= usable) begin
			seen = FULL_GROUP;
		end else if (grp == GROUP_W'(GROUP_COUNT - 1)) begin
			seen = data | LAST_PAD;
		end else begin
			seen = data;
		end
	end

	// highest clear bit wins
	always_comb begin
		idx = 3'd0;
		for (int b = 0; b < GROUP_BITS; b++) begin
			if (!seen[b]) begin
				idx = 3'(b);
			end
		end
	end

	assign res.full    = (seen == FULL_GROUP);
	assign res.bit_idx = idx;
	assign res.set_val = data | (8'h01 << idx);

endmodule

[rtl/page_frame_allocator.sv]
// page_frame_allocator: bitmap page allocator with a lifo cache of freed pages
// depends on pfa_pkg and pfa_scan_unit
// paths: free into cache or ignored free goes straight to ST_DONE, free into bitmap
//   via ST_CLR, allocate from cache via ST_POP, allocate by scan visits up to 16 groups
// one item at a time, the next accepted once ST_DONE is left; the bitmap scan visits
//   one group a cycle through the single bitmap read port and the shared scan unit
// reset: bitmap groups marked unwritten at once (group 0 reads 0x01, others 0),
//   cache empty, scan pointer 0, usable_groups 16; no clearing pass
module page_frame_allocator import pfa_pkg::*; #(
	parameter int PAGE_COUNT  = 128,
	parameter int CACHE_DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	// input beats
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [6:0] page, [7] zero fill
	input  logic       s_tuser,   // [0] command
	// result beats
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] granted_page, [7] zero fill
	output logic       m_tuser,   // [0] failed
	// configuration write
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] cfg_data   // [4:0] usable_groups
);

	localparam int GROUP_COUNT = (PAGE_COUNT + GROUP_BITS - 1) / GROUP_BITS;
	localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int CW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam int FW = $clog2(CACHE_DEPTH + 1);
	localparam logic [GW-1:0] LAST_GROUP = GW'(GROUP_COUNT - 1);

	state_t state_q, state_d;

	logic [USABLE_W-1:0] usable_q;
	logic [FW-1:0]       fill_q;
	logic [GW-1:0]       scan_group_q;
	logic [GW-1:0]       g_q;
	logic [GW-1:0]       n_q;
	logic [PAGE_W-1:0]   page_q;
	logic [PAGE_W-1:0]   res_page_q;
	logic                res_fail_q;
	logic                m_tvalid_q;
	logic [PAGE_W-1:0]   out_page_q;
	logic                out_fail_q;

	// bitmap memory with per-group written marks
	logic [GROUP_BITS-1:0]  bm_mem [GROUP_COUNT];
	logic [GROUP_COUNT-1:0] bm_valid_q;
	logic [GROUP_BITS-1:0]  bm_rd_q;
	logic [GW-1:0]          bm_raddr;
	logic                   bm_we;
	logic [GW-1:0]          bm_waddr;
	logic [GROUP_BITS-1:0]  bm_wdata;

	// freed-page cache memory
	logic [PAGE_W-1:0] cache_mem [CACHE_DEPTH];
	logic [PAGE_W-1:0] cache_rd_q;
	logic [CW-1:0]     cache_raddr;
	logic              cache_we;
	logic [FW-1:0]     fill_m1;

	logic          accept;
	logic          in_cmd;
	logic [PAGE_W-1:0] in_page;
	logic          page_ok;
	logic          cache_full;
	logic          out_free;
	logic [GW-1:0] g_next;
	logic [GW-1:0] in_group;
	scan_res_t     scan_res;

	assign in_cmd     = s_tuser;
	assign in_page    = s_tdata[PAGE_W-1:0];
	assign accept     = s_tvalid && s_tready;
	assign page_ok    = ({1'b0, in_page} < 8'(PAGE_COUNT));
	assign cache_full = (fill_q == FW'(CACHE_DEPTH));
	assign fill_m1    = fill_q - FW'(1);
	assign out_free   = !m_tvalid_q || m_tready;
	assign g_next     = (g_q == LAST_GROUP) ? '0 : g_q + GW'(1);
	assign in_group   = in_page[3 +: GW];
	assign cfg_ready  = 1'b1;

	// shared group checker
	pfa_scan_unit #(
		.PAGE_COUNT (PAGE_COUNT),
		.GROUP_W    (GW)
	) u_scan (
		.grp    (g_q),
		.data   (bm_rd_q),
		.usable (usable_q),
		.res    (scan_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_cmd == CMD_FREE) begin
						state_d = (page_ok && cache_full) ? ST_CLR : ST_DONE;
					end else begin
						state_d = (fill_q != '0) ? ST_POP : ST_SCAN;
					end
				end
			end
			ST_POP:  state_d = ST_DONE;
			ST_CLR:  state_d = ST_DONE;
			ST_SCAN: begin
				if (!scan_res.full || n_q == LAST_GROUP) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: handshake and memory controls
	always_comb begin
		s_tready    = 1'b0;
		bm_raddr    = g_next;
		bm_we       = 1'b0;
		bm_waddr    = g_q;
		bm_wdata    = scan_res.set_val;
		cache_we    = 1'b0;
		cache_raddr = fill_m1[CW-1:0];
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				bm_raddr = (in_cmd == CMD_FREE) ? in_group : scan_group_q;
				cache_we = accept && (in_cmd == CMD_FREE) && page_ok && !cache_full;
			end
			ST_CLR: begin
				bm_we    = 1'b1;
				bm_waddr = page_q[3 +: GW];
				bm_wdata = bm_rd_q & ~(8'h01 << page_q[2:0]);
			end
			ST_SCAN: begin
				bm_we = !scan_res.full;
			end
			default: begin
			end
		endcase
	end

	// bitmap memory write and registered read
	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_waddr] <= bm_wdata;
		end
		if (bm_valid_q[bm_raddr]) begin
			bm_rd_q <= bm_mem[bm_raddr];
		end else begin
			bm_rd_q <= (bm_raddr == '0) ? GROUP0_RESET : '0;
		end
	end

	// bitmap written marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bm_valid_q <= '0;
		end else if (bm_we) begin
			bm_valid_q[bm_waddr] <= 1'b1;
		end
	end

	// cache memory write and registered read
	always_ff @(posedge clk) begin
		if (cache_we) begin
			cache_mem[fill_q[CW-1:0]] <= in_page;
		end
		cache_rd_q <= cache_mem[cache_raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			usable_q     <= 5'd16;
			fill_q       <= '0;
			scan_group_q <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				usable_q <= cfg_data;
			end
			if (cache_we) begin
				fill_q <= fill_q + FW'(1);
			end else if (state_q == ST_IDLE && accept && in_cmd == CMD_ALLOC
					&& fill_q != '0) begin
				fill_q <= fill_m1;
			end
			if (state_q == ST_SCAN && !scan_res.full) begin
				scan_group_q <= g_q;
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// item payload, scan position and result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					page_q     <= in_page;
					g_q        <= scan_group_q;
					n_q        <= '0;
					res_page_q <= '0;
					res_fail_q <= 1'b0;
				end
			end
			ST_POP: begin
				res_page_q <= cache_rd_q;
			end
			ST_SCAN: begin
				if (!scan_res.full) begin
					res_page_q <= PAGE_W'({g_q, scan_res.bit_idx});
				end else if (n_q == LAST_GROUP) begin
					res_fail_q <= 1'b1;
				end else begin
					g_q <= g_next;
					n_q <= n_q + GW'(1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_page_q <= res_page_q;
					out_fail_q <= res_fail_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_page_q};
	assign m_tuser  = out_fail_q;

	// an accepted item drops s_tready, holding off the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input accepted twice in a row");

	// a failed allocate hands out page zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == 8'd0))
		else $error("failed result with nonzero page");

	// the cache never overfills
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(CACHE_DEPTH))
		else $error("cache fill beyond depth");

	// a scan never visits more groups than exist
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (n_q <= LAST_GROUP && g_q <= LAST_GROUP))
		else $error("scan position out of range");

endmodule

[test/tb_page_frame_allocator.sv]
// tb_page_frame_allocator: self-checking bench for the page frame allocator
// depends on pfa_pkg and page_frame_allocator; predicts every grant from its own
//   copy of the busy bitmap, freed-page stack, scan pointer and usable_groups
module tb_page_frame_allocator;
	import pfa_pkg::*;

	localparam int PAGE_COUNT  = 128;
	localparam int CACHE_DEPTH = 8;
	localparam int GROUP_COUNT = (PAGE_COUNT + 7) / 8;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [6:0] page, [7] zero fill
	logic       s_tuser;   // [0] command
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [6:0] granted_page, [7] zero fill
	logic       m_tuser;   // [0] failed
	logic       cfg_valid;
	logic       cfg_ready;
	logic [4:0] cfg_data;  // [4:0] usable_groups

	// one predicted result beat
	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic              failed;
	} grant_t;

	// predictor of the allocator plus the queue of grants still owed by the block
	class alloc_scoreboard;
		logic [GROUP_BITS-1:0] busy_map [GROUP_COUNT];
		logic [PAGE_W-1:0]     freed_stack [CACHE_DEPTH];
		int unsigned           stack_fill;
		int unsigned           scan_ptr;
		logic [USABLE_W-1:0]   usable;
		grant_t                owed_q[$];
		int errors, alloc_count, fail_count, cache_pops;
		int free_count, cache_pushes, bitmap_clears;

		function new();
			for (int g = 0; g < GROUP_COUNT; g++)
				busy_map[g] = '0;
			busy_map[0] = GROUP0_RESET;
			stack_fill = 0;
			scan_ptr = 0;
			usable = 5'd16;
			errors = 0;
			alloc_count = 0;
			fail_count = 0;
			cache_pops = 0;
			free_count = 0;
			cache_pushes = 0;
			bitmap_clears = 0;
		endfunction

		function void set_usable(logic [USABLE_W-1:0] v);
			usable = v;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function void flag_error(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		// group as the scan sees it: unusable groups and missing pages read busy
		function logic [GROUP_BITS-1:0] seen_group(int unsigned g);
			logic [GROUP_BITS-1:0] v;
			if (g >= usable)
				return FULL_GROUP;
			v = busy_map[g];
			if (g * 8 + 8 > PAGE_COUNT)
				v = v | (FULL_GROUP << (PAGE_COUNT - g * 8));
			return v;
		endfunction

		// apply one accepted request and queue the grant it must produce
		function grant_t note_request(logic cmd, logic [PAGE_W-1:0] pg);
			grant_t                r;
			logic [GROUP_BITS-1:0] v;
			int unsigned           g;
			int                    n;
			int                    b;
			bit                    found;
			r.page = '0;
			r.failed = 1'b0;
			if (cmd == CMD_ALLOC) begin
				alloc_count++;
				if (stack_fill > 0) begin
					stack_fill--;
					r.page = freed_stack[stack_fill];
					cache_pops++;
				end else begin
					// circular scan, highest clear bit of the first non-full group
					g = scan_ptr % GROUP_COUNT;
					found = 1'b0;
					for (n = 0; n < GROUP_COUNT && !found; n++) begin
						v = seen_group(g);
						if (v != FULL_GROUP) begin
							for (b = 7; b >= 0 && !found; b--) begin
								if (!v[b]) begin
									busy_map[g][b] = 1'b1;
									r.page = PAGE_W'(g * 8 + b);
									found = 1'b1;
								end
							end
						end else begin
							g = (g + 1) % GROUP_COUNT;
						end
					end
					scan_ptr = g;
					if (!found) begin
						r.failed = 1'b1;
						fail_count++;
					end
				end
			end else if (pg < PAGE_COUNT) begin
				free_count++;
				if (stack_fill < CACHE_DEPTH) begin
					freed_stack[stack_fill] = pg;
					stack_fill++;
					cache_pushes++;
				end else begin
					busy_map[pg >> 3][pg[2:0]] = 1'b0;
					bitmap_clears++;
				end
			end
			owed_q.push_back(r);
			return r;
		endfunction

		function void check_grant(logic [PAGE_W-1:0] pg, logic failed);
			grant_t want;
			if (owed_q.size() == 0) begin
				flag_error($sformatf("unexpected result beat: page %0d failed %0b", pg, failed));
				return;
			end
			want = owed_q.pop_front();
			if (pg !== want.page || failed !== want.failed)
				flag_error($sformatf("grant mismatch: expected page %0d failed %0b, got page %0d failed %0b",
					want.page, want.failed, pg, failed));
		endfunction

		function void close_out();
			if (owed_q.size() != 0)
				flag_error($sformatf("%0d expected results never arrived", owed_q.size()));
		endfunction
	endclass

	alloc_scoreboard   board;
	logic [PAGE_W-1:0] held_pages[$];
	bit                steady_flow;
	int                setting_count;

	page_frame_allocator #(
		.PAGE_COUNT (PAGE_COUNT),
		.CACHE_DEPTH(CACHE_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop
	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

	// result side: random stall before each beat (none in steady flow), then check it
	initial begin : result_sink
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			board.check_grant(m_tdata[PAGE_W-1:0], m_tuser);
		end
	end

	// one request beat after a random gap (none in steady flow); allocated pages are kept for later frees
	task automatic send_request(input logic cmd, input logic [PAGE_W-1:0] pg);
		int     gap;
		grant_t g;
		gap = steady_flow ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, pg};
		s_tuser  <= cmd;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		g = board.note_request(cmd, pg);
		if (cmd == CMD_ALLOC && !g.failed)
			held_pages.push_back(g.page);
	endtask

	// stop sending and wait for every owed grant
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	// register write with the block idle
	task automatic write_usable(input logic [USABLE_W-1:0] v);
		hold_until_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		board.set_usable(v);
		setting_count++;
	endtask

	// random mix: mostly allocates and frees of held pages, some stray frees
	task automatic run_phase(input logic [USABLE_W-1:0] usable, input int alloc_pct,
		input int count);
		int                pause_at;
		int                idx;
		logic [PAGE_W-1:0] pg;
		write_usable(usable);
		steady_flow = ($urandom_range(0, 3) == 0);
		pause_at = $urandom_range(0, count - 1);
		for (int k = 0; k < count; k++) begin
			if (k == pause_at)
				hold_until_drained();
			if ($urandom_range(1, 100) <= alloc_pct) begin
				send_request(CMD_ALLOC, PAGE_W'($urandom_range(0, PAGE_COUNT - 1)));
			end else if (held_pages.size() > 0 && $urandom_range(1, 100) <= 85) begin
				idx = $urandom_range(0, held_pages.size() - 1);
				pg = held_pages[idx];
				held_pages.delete(idx);
				send_request(CMD_FREE, pg);
			end else begin
				send_request(CMD_FREE, PAGE_W'($urandom_range(0, PAGE_COUNT - 1)));
			end
		end
	endtask

	// main sequence
	initial begin : stimulus
		board = new();
		setting_count = 0;
		steady_flow = 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= CMD_ALLOC;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no usable groups and an empty stack: allocate fails
		write_usable(5'd0);
		send_request(CMD_ALLOC, 7'd0);

		// full range: first grant from group 0, stack push and pop, overflow to bitmap
		write_usable(5'd16);
		send_request(CMD_ALLOC, 7'd127);
		send_request(CMD_FREE, 7'd127);
		send_request(CMD_FREE, 7'd0);
		send_request(CMD_ALLOC, 7'd0);
		send_request(CMD_FREE, 7'd5);
		send_request(CMD_FREE, 7'd7);
		send_request(CMD_FREE, 7'd1);
		send_request(CMD_FREE, 7'd2);
		send_request(CMD_FREE, 7'd3);
		send_request(CMD_FREE, 7'd4);
		send_request(CMD_FREE, 7'd64);
		// stack full: free of a page already free, then page 0 back to the bitmap
		send_request(CMD_FREE, 7'd85);
		send_request(CMD_FREE, 7'd0);
		send_request(CMD_ALLOC, 7'd42);

		// random phases across settings, the extremes among them
		run_phase(5'd16, 55, 150);
		run_phase(5'd1, 60, 150);
		run_phase(5'd31, 50, 150);
		run_phase(5'd2, 70, 150);
		run_phase(5'd0, 40, 150);
		run_phase(5'd17, 60, 150);
		run_phase(5'd5, 75, 150);
		run_phase(5'd8, 50, 150);
		run_phase(5'd16, 95, 150);
		run_phase(5'd3, 65, 150);

		// wind down: everything owed, then a margin for stray beats
		hold_until_drained();
		repeat (40) @(posedge clk);
		board.close_out();

		$display("covered %0d allocates (%0d from the free stack, %0d failed), %0d frees (%0d stacked, %0d to the bitmap)",
			board.alloc_count, board.cache_pops, board.fail_count,
			board.free_count, board.cache_pushes, board.bitmap_clears);
		$display("over %0d usable_groups writes from 0 up to 31; %0d errors",
			setting_count, board.errors);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[filelist.f]
rtl/pfa_pkg.sv
rtl/pfa_scan_unit.sv
rtl/page_frame_allocator.sv
test/tb_page_frame_allocator.sv
